// ===== design/rhe_pkg.sv =====
// Shared constants and types for the RGB histogram equaliser.
package rhe_pkg;

    localparam int BINS       = 256;
    localparam int CHANNELS   = 3;
    localparam int COUNT_BITS = 24;

    localparam int BIN_W  = $clog2(BINS);
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    // Running sum of one histogram, and the divider's working width
    localparam int SUM_W  = COUNT_BITS + BIN_W;
    localparam int NUM_W  = SUM_W + 10;
    localparam int Q_W    = 8;
    localparam int STEP_W = $clog2(Q_W);

    typedef enum logic [1:0] {
        FN_CLEAR = 2'd0,
        FN_ACC   = 2'd1,
        FN_BUILD = 2'd2,
        FN_MAP   = 2'd3
    } t_func;

endpackage

// ===== design/rhe_divider.sv =====
// Shared restoring divider: quotient of (run*510 + top) / (2*top), eight bits.
module rhe_divider
    import rhe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SUM_W-1:0] i_run,
    input  logic [SUM_W-1:0] i_top,
    output logic             o_done,
    output logic [Q_W-1:0]   o_quot
);

    logic [NUM_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_div;
    logic [Q_W-1:0]    r_q;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;

    logic [NUM_W-1:0]  n_num;
    logic              w_ge;

    // numerator: run*510 as two shifts and a subtract, plus top
    assign n_num = NUM_W'({i_run, 9'b0}) - NUM_W'({i_run, 1'b0}) + NUM_W'(i_top);
    assign w_ge  = (r_rem >= r_div);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= n_num;
                r_div  <= NUM_W'({i_top, 1'b0, {(Q_W-1){1'b0}}});
                r_q    <= '0;
                r_step <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                // one quotient bit a cycle, most significant first
                if (w_ge) begin
                    r_rem <= r_rem - r_div;
                end
                r_q    <= {r_q[Q_W-2:0], w_ge};
                r_div  <= r_div >> 1;
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(Q_W-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== design/rgb_histogram_equalizer.sv =====
// Top level: histogram and table stores, command sequencer and map path.
// Commands are taken while o_busy is low; results cannot be held off. After reset
// a clearing pass zeroes histograms and tables (o_busy high); a clear command zeroes
// only the histograms, one bin row a cycle. Accumulate is a read-modify-write of one
// histogram port; map raises o_valid for one cycle with the looked-up values. Build:
// per channel one pass sums all bins but the last, a second walks the bins through
// the shared eight-step divider.
module rgb_histogram_equalizer
    import rhe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    output logic       o_busy,
    input  logic [1:0] i_func,
    input  logic [7:0] i_chan0_in,
    input  logic [7:0] i_chan1_in,
    input  logic [7:0] i_chan2_in,
    output logic       o_valid,
    output logic [7:0] o_chan0_out,
    output logic [7:0] o_chan1_out,
    output logic [7:0] o_chan2_out,
    output logic       o_tables_ready
);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_CLR     = 10'b0000000010,
        S_ACC_RD  = 10'b0000000100,
        S_ACC_WR  = 10'b0000001000,
        S_A_RD    = 10'b0000010000,
        S_A_ACC   = 10'b0000100000,
        S_B_RD    = 10'b0001000000,
        S_B_DIV   = 10'b0010000000,
        S_MAP_RD  = 10'b0100000000,
        S_MAP_OUT = 10'b1000000000
    } t_state;

    t_state r_state;
    logic [BIN_W-1:0] r_idx;
    logic [CH_W-1:0]  r_ch;
    logic             r_clr_tab;
    logic             r_built;
    logic [SUM_W-1:0] r_top;
    logic [SUM_W-1:0] r_run;
    logic [BIN_W-1:0] r_val [CHANNELS];

    // stores
    logic [COUNT_BITS-1:0] hist [CHANNELS][BINS];
    logic [7:0]            tab  [CHANNELS][BINS];
    logic [COUNT_BITS-1:0] r_hq [CHANNELS];
    logic [7:0]            r_tq [CHANNELS];

    logic [BIN_W-1:0] w_in [CHANNELS];
    logic [BIN_W-1:0] w_hraddr;
    logic             w_build;
    logic             w_accept;
    logic             w_div_done;
    logic [Q_W-1:0]   w_quot;
    logic [COUNT_BITS-1:0] w_h;

    assign w_in[0] = i_chan0_in;
    assign w_in[1] = i_chan1_in;
    assign w_in[2] = i_chan2_in;

    assign w_accept = i_start && !o_busy;
    assign w_build  = (r_state == S_A_RD) || (r_state == S_A_ACC) ||
                      (r_state == S_B_RD) || (r_state == S_B_DIV);
    assign w_hraddr = r_idx;
    assign w_h      = r_hq[r_ch];

    rhe_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_B_RD),
        .i_run   (r_run),
        .i_top   (r_top),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // histogram store: one write and one registered read per channel
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < CHANNELS; c++) begin
            if (r_state == S_CLR) begin
                hist[c][r_idx] <= '0;
            end else if (r_state == S_ACC_WR && r_hq[c] != '1) begin
                hist[c][r_val[c]] <= r_hq[c] + 1'b1;
            end
            r_hq[c] <= hist[c][w_build ? w_hraddr : r_val[c]];
        end
    end

    // table store: swept at reset, written by build, read by map
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < CHANNELS; c++) begin
            if (r_state == S_CLR && r_clr_tab) begin
                tab[c][r_idx] <= '0;
            end else if (r_state == S_B_DIV && w_div_done && r_ch == CH_W'(c)) begin
                tab[c][r_idx] <= (r_top == '0) ? 8'd0 : w_quot;
            end
            r_tq[c] <= tab[c][r_val[c]];
        end
    end

    // command sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_idx     <= '0;
            r_ch      <= '0;
            r_clr_tab <= 1'b1;
            r_built   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        for (int c = 0; c < CHANNELS; c++) begin
                            r_val[c] <= w_in[c];
                        end
                        r_idx <= '0;
                        r_ch  <= '0;
                        r_top <= '0;
                        case (t_func'(i_func))
                            FN_CLEAR: begin
                                r_state <= S_CLR;
                                r_built <= 1'b0;
                            end
                            FN_ACC:   r_state <= S_ACC_RD;
                            FN_BUILD: r_state <= S_A_RD;
                            FN_MAP:   r_state <= S_MAP_RD;
                            default:  r_state <= S_IDLE;
                        endcase
                    end
                end
                S_CLR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == BIN_W'(BINS-1)) begin
                        r_clr_tab <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
                S_ACC_RD: r_state <= S_ACC_WR;
                S_ACC_WR: r_state <= S_IDLE;
                S_A_RD:   r_state <= S_A_ACC;
                S_A_ACC: begin
                    // max is the exclusive sum at the last bin
                    if (r_idx != BIN_W'(BINS-1)) begin
                        r_top   <= r_top + SUM_W'(w_h);
                        r_state <= S_A_RD;
                    end else begin
                        r_run   <= '0;
                        r_state <= S_B_RD;
                    end
                    r_idx <= r_idx + 1'b1;
                end
                S_B_RD: r_state <= S_B_DIV;
                S_B_DIV: begin
                    if (w_div_done) begin
                        r_run <= r_run + SUM_W'(w_h);
                        r_idx <= r_idx + 1'b1;
                        if (r_idx != BIN_W'(BINS-1)) begin
                            r_state <= S_B_RD;
                        end else if (r_ch == CH_W'(CHANNELS-1)) begin
                            r_built <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_ch    <= r_ch + 1'b1;
                            r_top   <= '0;
                            r_state <= S_A_RD;
                        end
                    end
                end
                S_MAP_RD:  r_state <= S_MAP_OUT;
                S_MAP_OUT: r_state <= S_IDLE;
                default:   r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_valid        = (r_state == S_MAP_OUT);
    assign o_chan0_out    = r_tq[0];
    assign o_chan1_out    = r_tq[1];
    assign o_chan2_out    = r_tq[2];
    assign o_tables_ready = r_built;

    // a map beat comes in S_MAP_OUT, after S_MAP_RD, and never twice running
    a_map_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_func == FN_MAP) |=> ##1 o_valid)
        else $error("map beat late");
    a_no_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("map beats back to back");
    // divider only finishes while the sequencer waits for it
    a_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_B_DIV))
        else $error("divider done out of place");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the RGB histogram equaliser: command stimulus, prediction, checks.
module tb_top
    import rhe_pkg::*;
();

    // Equalisation predictor and store of pending mapped pixels
    class equaliser_scoreboard;
        logic [COUNT_BITS-1:0] hist [3][BINS];
        logic [7:0]            lut  [3][BINS];
        logic                  built;
        logic [24:0]           pending_pixels [$];
        int                    mismatches;

        function new();
            for (int c = 0; c < 3; c++)
                for (int b = 0; b < BINS; b++) begin
                    hist[c][b] = '0;
                    lut[c][b]  = '0;
                end
            built      = 1'b0;
            mismatches = 0;
        endfunction

        // Exclusive prefix sum, then round-half-up scaling against the last prefix
        function void build_tables();
            longint unsigned prefix [BINS];
            longint unsigned run;
            longint unsigned top;
            longint unsigned v;
            for (int c = 0; c < 3; c++) begin
                run = 0;
                for (int b = 0; b < BINS; b++) begin
                    prefix[b] = run;
                    run += hist[c][b];
                end
                top = prefix[BINS-1];
                for (int b = 0; b < BINS; b++) begin
                    v = 0;
                    if (top != 0) begin
                        v = (prefix[b] * 510 + top) / (top * 2);
                        if (v > 255) v = 255;
                    end
                    lut[c][b] = v[7:0];
                end
            end
            built = 1'b1;
        endfunction

        // Update the model with one accepted command beat
        function void note_command(t_func f, logic [7:0] c0, logic [7:0] c1,
                                   logic [7:0] c2);
            logic [7:0] px [3];
            px = '{c0, c1, c2};
            case (f)
                FN_CLEAR: begin
                    for (int c = 0; c < 3; c++)
                        for (int b = 0; b < BINS; b++) hist[c][b] = '0;
                    built = 1'b0;
                end
                FN_ACC: begin
                    for (int c = 0; c < 3; c++)
                        if (hist[c][px[c]] != {COUNT_BITS{1'b1}})
                            hist[c][px[c]] = hist[c][px[c]] + 1'b1;
                end
                FN_BUILD: build_tables();
                FN_MAP: pending_pixels.push_back({lut[0][c0], lut[1][c1], lut[2][c2], built});
                default: ;
            endcase
        endfunction

        function void check_pixel(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2, logic rdy);
            logic [24:0] exp_px;
            logic [24:0] got;
            got = {c0, c1, c2, rdy};
            if (pending_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", got);
                return;
            end
            exp_px = pending_pixels.pop_front();
            if (exp_px !== got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"pixel mismatch: exp ch0=%h ch1=%h ch2=%h rdy=%b, ",
                              "got ch0=%h ch1=%h ch2=%h rdy=%b"},
                             exp_px[24:17], exp_px[16:9], exp_px[8:1], exp_px[0],
                             c0, c1, c2, rdy);
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_start = 1'b0;
    logic       o_busy;
    logic [1:0] i_func = FN_CLEAR;
    logic [7:0] i_chan0_in = '0;
    logic [7:0] i_chan1_in = '0;
    logic [7:0] i_chan2_in = '0;
    logic       o_valid;
    logic [7:0] o_chan0_out;
    logic [7:0] o_chan1_out;
    logic [7:0] o_chan2_out;
    logic       o_tables_ready;

    equaliser_scoreboard sb = new();
    int idle_pct = 12;
    int beats_sent = 0;

    rgb_histogram_equalizer i_dut (.*);

    always #5 i_clk = ~i_clk;

    // Result monitor
    always @(posedge i_clk)
        if (i_rst_n && o_valid === 1'b1)
            sb.check_pixel(o_chan0_out, o_chan1_out, o_chan2_out, o_tables_ready);

    // Drive one command beat and wait for it to be taken
    task automatic send_cmd(t_func f, logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
        if ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_start    <= 1'b1;
        i_func     <= f;
        i_chan0_in <= c0;
        i_chan1_in <= c1;
        i_chan2_in <= c2;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        sb.note_command(f, c0, c1, c2);
        beats_sent++;
    endtask

    task automatic drain();
        i_start <= 1'b0;
        while (sb.pending_pixels.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] skewed_value(logic [7:0] base, int spread);
        return base + 8'($urandom_range(spread));
    endfunction

    // Stimulus
    initial begin
        int n_acc;
        int n_map;
        int spread;
        logic [7:0] base [3];
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: map from reset tables, empty build, extremes, one-bin channel
        send_cmd(FN_MAP, 8'h00, 8'hFF, 8'h5A);
        send_cmd(FN_BUILD, 8'h00, 8'h00, 8'h00);
        send_cmd(FN_MAP, 8'hFF, 8'h00, 8'hA5);
        send_cmd(FN_CLEAR, 8'hFF, 8'hFF, 8'hFF);
        send_cmd(FN_ACC, 8'hFF, 8'h00, 8'hFF);
        send_cmd(FN_ACC, 8'hFF, 8'hFF, 8'h00);
        send_cmd(FN_ACC, 8'hFF, 8'h80, 8'h01);
        send_cmd(FN_ACC, 8'hFF, 8'h7F, 8'hFE);
        send_cmd(FN_BUILD, 8'h00, 8'h00, 8'h00);
        send_cmd(FN_MAP, 8'h00, 8'h00, 8'h00);
        send_cmd(FN_MAP, 8'hFF, 8'hFF, 8'hFF);
        send_cmd(FN_MAP, 8'h55, 8'h80, 8'h7F);
        send_cmd(FN_MAP, 8'hAA, 8'h01, 8'hFE);
        send_cmd(FN_CLEAR, 8'h00, 8'h00, 8'h00);
        send_cmd(FN_MAP, 8'hFF, 8'h80, 8'h01);
        send_cmd(FN_ACC, 8'h00, 8'h00, 8'h00);
        send_cmd(FN_MAP, 8'h00, 8'hFF, 8'hFE);
        drain();

        // Random rounds: mostly clear / accumulate / build / map, some noise
        while (beats_sent < 550) begin
            idle_pct = (beats_sent < 190) ? 12 : (beats_sent < 370) ? 66 : 0;
            if ($urandom_range(99) < 80) begin
                if ($urandom_range(3) != 0)
                    send_cmd(FN_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom));
                n_acc  = $urandom_range(1, 40);
                spread = $urandom_range(1) ? 255 : $urandom_range(0, 15);
                for (int c = 0; c < 3; c++) base[c] = 8'($urandom);
                repeat (n_acc)
                    send_cmd(FN_ACC, skewed_value(base[0], spread),
                             skewed_value(base[1], spread), skewed_value(base[2], spread));
                if ($urandom_range(7) != 0)
                    send_cmd(FN_BUILD, 8'($urandom), 8'($urandom), 8'($urandom));
                n_map = $urandom_range(1, 20);
                repeat (n_map)
                    send_cmd(FN_MAP, 8'($urandom), 8'($urandom), 8'($urandom));
            end else begin
                repeat ($urandom_range(1, 10))
                    send_cmd($urandom_range(2) == 2 ? FN_MAP : t_func'($urandom_range(1)),
                             8'($urandom), 8'($urandom), 8'($urandom));
            end
            // Pause until every mapped pixel is back
            if ($urandom_range(4) == 0) drain();
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_pixels.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Run limit
    initial begin
        #200000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
